@@ hdl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer: command and
// register codes, the decoded tick item, the result item and the config set.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // command codes on the cmd input
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_STOP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [7:0] START_STOP_RST  = 8'd4;
    localparam logic [7:0] BIT_PHASE_RST   = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // depth of each item queue
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } tick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_failed;
        logic [7:0] rx_byte;
    } res_t;

    typedef struct packed {
        logic [7:0] start_stop_ticks;
        logic [7:0] bit_phase_ticks;
        logic [7:0] ack_timeout_ticks;
    } cfg_t;

endpackage

@@ hdl/i2c_master_bit_sequencer.sv @@
// Throughput: one tick item per clock cycle, sustained while results are popped.
// An accepted item is written into the input queue; the sequencer step then writes
// its result into the result queue, from which it can be popped.
// Each item is one step of the phase sequencer; the input and result queues
// let either side stall without at once stopping the other.
// Reset (rst_n low, asynchronous): both queues empty, bus idle with SCL, SDA high.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Tick-driven I2C master: start, stop, byte write with ACK check and byte
// read with ACK or NACK answer; one result item of bus levels per tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
    parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data,
    // tick items in
    input  logic                              push,
    output logic                              full,
    input  logic [2:0]                        cmd,
    input  logic [7:0]                        tx_byte,
    input  logic                              send_ack,
    input  logic                              sda_sample,
    // result items out
    output logic                              empty,
    input  logic                              pop,
    output logic                              scl_level,
    output logic                              sda_level,
    output logic                              sda_drive,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              ack_failed,
    output logic [7:0]                        rx_byte
);

    import i2cms_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  item_valid;
    tick_t item;
    logic  item_pop;
    logic  res_full;
    logic  res_push;
    res_t  res_in;
    res_t  res_out;

    // Registers take writes at any time; the host must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_STOP:  cfg_next.start_stop_ticks  = cfg_data;
                REG_BIT_PHASE:   cfg_next.bit_phase_ticks   = cfg_data;
                REG_ACK_TIMEOUT: cfg_next.ack_timeout_ticks = cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_stop_ticks  <= START_STOP_RST;
            cfg_reg.bit_phase_ticks   <= BIT_PHASE_RST;
            cfg_reg.ack_timeout_ticks <= ACK_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify the command and hold ticks until the sequencer takes them.
    i2cms_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .tx_byte    (tx_byte),
        .send_ack   (send_ack),
        .sda_sample (sda_sample),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Back: advance the bus phases one tick whenever an item is queued and a result slot is free.
    i2cms_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    // Result queue: hold finished ticks until the consumer pops them.
    i2cms_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign scl_level  = res_out.scl_level;
    assign sda_level  = res_out.sda_level;
    assign sda_drive  = res_out.sda_drive;
    assign busy_res   = res_out.busy_res;
    assign done_res   = res_out.done_res;
    assign ack_failed = res_out.ack_failed;
    assign rx_byte    = res_out.rx_byte;

endmodule

@@ hdl/i2cms_fifo.sv @@
// ----------------------------------------------------------------------------
// i2cms_fifo
// Small first-in first-out item queue with full and empty flags.
// ----------------------------------------------------------------------------
module i2cms_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/i2cms_front.sv @@
// ----------------------------------------------------------------------------
// i2cms_front
// Accept tick items, classify the command code and queue them for the
// sequencer.
// ----------------------------------------------------------------------------
module i2cms_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       cmd,
    input  logic [7:0]       tx_byte,
    input  logic             send_ack,
    input  logic             sda_sample,
    output logic             item_valid,
    output i2cms_pkg::tick_t item,
    input  logic             item_pop
);

    import i2cms_pkg::*;

    tick_t item_in;
    logic  q_empty;

    // map unused codes onto no command
    always_comb
    begin
        item_in.tx_byte    = tx_byte;
        item_in.send_ack   = send_ack;
        item_in.sda_sample = sda_sample;
        case (cmd)
            CMD_START: item_in.op = OP_START;
            CMD_STOP:  item_in.op = OP_STOP;
            CMD_WRITE: item_in.op = OP_WRITE;
            CMD_READ:  item_in.op = OP_READ;
            default:   item_in.op = OP_NONE;
        endcase
    end

    i2cms_fifo #(
        .WIDTH ($bits(tick_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (item_pop),
        .rdata (item),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;

endmodule

@@ hdl/i2cms_seq.sv @@
// ----------------------------------------------------------------------------
// i2cms_seq
// Bus phase sequencer: advance one tick per queued item and produce the
// bus levels and status of that tick.
// ----------------------------------------------------------------------------
module i2cms_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  i2cms_pkg::cfg_t  cfg,
    input  logic             item_valid,
    input  i2cms_pkg::tick_t item,
    output logic             item_pop,
    input  logic             res_full,
    output logic             res_push,
    output i2cms_pkg::res_t  res
);

    import i2cms_pkg::*;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_ST_A    = 14'b00000000000010,
        PH_ST_B    = 14'b00000000000100,
        PH_SP_A    = 14'b00000000001000,
        PH_SP_B    = 14'b00000000010000,
        PH_WR_SET  = 14'b00000000100000,
        PH_WR_HI   = 14'b00000001000000,
        PH_WR_HOLD = 14'b00000010000000,
        PH_AK_REL  = 14'b00000100000000,
        PH_AK_WAIT = 14'b00001000000000,
        PH_RD_LO   = 14'b00010000000000,
        PH_RD_HI   = 14'b00100000000000,
        PH_AC_LO   = 14'b01000000000000,
        PH_AC_HI   = 14'b10000000000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] wait_reg, wait_next;
    logic       ackc_reg, ackc_next;
    logic       fail_reg, fail_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drive_reg, drive_next;
    logic [7:0] rx_reg, rx_next;
    logic       done;
    logic       step;
    logic [8:0] tc;
    logic       end_ss;
    logic       end_bp;

    assign step     = item_valid && !res_full;
    assign item_pop = step;
    assign res_push = step;

    assign tc     = {1'b0, tick_reg} + 9'd1;
    assign end_ss = tc >= {1'b0, cfg.start_stop_ticks};
    assign end_bp = tc >= {1'b0, cfg.bit_phase_ticks};

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        ackc_next  = ackc_reg;
        fail_next  = fail_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                case (item.op)
                    OP_START:
                    begin
                        phase_next = PH_ST_A;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        drive_next = 1'b1;
                        tick_next  = '0;
                    end
                    OP_STOP:
                    begin
                        phase_next = PH_SP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        drive_next = 1'b1;
                        tick_next  = '0;
                    end
                    OP_WRITE:
                    begin
                        shift_next = item.tx_byte;
                        bit_next   = '0;
                        wait_next  = '0;
                        fail_next  = 1'b0;
                        phase_next = PH_WR_SET;
                        scl_next   = 1'b0;
                        sda_next   = item.tx_byte[7];
                        drive_next = 1'b1;
                        tick_next  = '0;
                    end
                    OP_READ:
                    begin
                        shift_next = '0;
                        bit_next   = '0;
                        ackc_next  = item.send_ack;
                        phase_next = PH_RD_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        drive_next = 1'b0;
                        tick_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                tick_next = tc[7:0];
                case (phase_reg)
                    PH_ST_A:
                    begin
                        if (end_ss)
                        begin
                            phase_next = PH_ST_B;
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                            drive_next = 1'b1;
                            tick_next  = '0;
                        end
                    end
                    PH_ST_B:
                    begin
                        if (end_ss)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                            done       = 1'b1;
                        end
                    end
                    PH_SP_A:
                    begin
                        if (end_ss)
                        begin
                            phase_next = PH_SP_B;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            drive_next = 1'b1;
                            tick_next  = '0;
                        end
                    end
                    PH_SP_B:
                    begin
                        if (end_ss)
                        begin
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                            done       = 1'b1;
                        end
                    end
                    PH_WR_SET:
                    begin
                        if (end_bp)
                        begin
                            phase_next = PH_WR_HI;
                            scl_next   = 1'b1;
                            drive_next = 1'b1;
                            tick_next  = '0;
                        end
                    end
                    PH_WR_HI:
                    begin
                        if (end_bp)
                        begin
                            phase_next = PH_WR_HOLD;
                            scl_next   = 1'b0;
                            drive_next = 1'b1;
                            tick_next  = '0;
                        end
                    end
                    PH_WR_HOLD:
                    begin
                        if (end_bp)
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 1'b1;
                            tick_next  = '0;
                            scl_next   = 1'b0;
                            if (bit_next < BITS_PER_BYTE)
                            begin
                                phase_next = PH_WR_SET;
                                sda_next   = shift_reg[6];
                                drive_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_AK_REL;
                                sda_next   = 1'b1;
                                drive_next = 1'b0;
                            end
                        end
                    end
                    PH_AK_REL:
                    begin
                        phase_next = PH_AK_WAIT;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        drive_next = 1'b0;
                        tick_next  = '0;
                        wait_next  = '0;
                    end
                    PH_AK_WAIT:
                    begin
                        tick_next = '0;
                        if (!item.sda_sample)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else if (wait_reg >= cfg.ack_timeout_ticks)
                        begin
                            fail_next  = 1'b1;
                            phase_next = PH_SP_A;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            drive_next = 1'b1;
                        end
                        else
                        begin
                            wait_next = wait_reg + 1'b1;
                        end
                    end
                    PH_RD_LO:
                    begin
                        if (end_bp)
                        begin
                            phase_next = PH_RD_HI;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            drive_next = 1'b0;
                            tick_next  = '0;
                        end
                    end
                    PH_RD_HI:
                    begin
                        if (end_bp)
                        begin
                            shift_next = {shift_reg[6:0], item.sda_sample};
                            bit_next   = bit_reg + 1'b1;
                            tick_next  = '0;
                            scl_next   = 1'b0;
                            if (bit_next < BITS_PER_BYTE)
                            begin
                                phase_next = PH_RD_LO;
                                sda_next   = 1'b1;
                                drive_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_AC_LO;
                                sda_next   = !ackc_reg;
                                drive_next = 1'b1;
                            end
                        end
                    end
                    PH_AC_LO:
                    begin
                        if (end_bp)
                        begin
                            phase_next = PH_AC_HI;
                            scl_next   = 1'b1;
                            drive_next = 1'b1;
                            tick_next  = '0;
                        end
                    end
                    PH_AC_HI:
                    begin
                        if (end_bp)
                        begin
                            scl_next   = 1'b0;
                            rx_next    = shift_reg;
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                endcase
            end
        end
    end

    // result reflects the state after this tick
    always_comb
    begin
        res.scl_level  = scl_next;
        res.sda_level  = drive_next ? sda_next : 1'b1;
        res.sda_drive  = drive_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.ack_failed = fail_next;
        res.rx_byte    = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            wait_reg  <= '0;
            ackc_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drive_reg <= 1'b1;
            rx_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            wait_reg  <= wait_next;
            ackc_reg  <= ackc_next;
            fail_reg  <= fail_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            rx_reg    <= rx_next;
        end
    end

    // a low ACK sample ends the write with SCL low
    a_ack_seen_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_AK_WAIT) && !item.sda_sample
        |=> (phase_reg == PH_IDLE) && !scl_reg)
        else $error("ACK sample did not end the write");

    // a write command clears the failure flag and starts the first bit
    a_write_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_IDLE) && (item.op == OP_WRITE)
        |=> (phase_reg == PH_WR_SET) && !fail_reg && (bit_reg == '0))
        else $error("write command did not start cleanly");

    // the bit counter never passes one byte
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BITS_PER_BYTE)
        else $error("bit counter out of range");

    // without a tick the sequencer holds still
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(tick_reg) && $stable(wait_reg))
        else $error("sequencer moved without a tick");

endmodule
